// File: rtl/lav_pkg.sv
// Package for the look-at view matrix block: shared widths, pipeline depths,
// the side-band type of the normalizer and the rounding helpers.
// No dependencies; used by lav_norm and look_at_view_matrix.
package lav_pkg;

   localparam int AXIS_FRAC = 30;
   localparam int MAG_W     = 30;   // normalized magnitude width
   localparam int ROOT_W    = 31;   // square root bits, one per stage
   localparam int QUO_W     = 31;   // quotient bits, one per stage
   localparam int NORM_LAT  = 5 + ROOT_W + 1 + QUO_W + 1;
   localparam int PIPE_LAT  = 10 + 2 * NORM_LAT;

   typedef logic signed [31:0] word_type;
   typedef logic signed [63:0] wide_type;

   typedef struct packed {
      logic [2:0]             neg;
      logic                   zero;
      logic [2:0][MAG_W-1:0]  mag;
   } norm_side_type;

   // Shift right by the axis fraction, rounding half away from zero.
   function automatic wide_type round_axis(input wide_type v);
      logic [63:0] mag;
      logic [63:0] r;
      mag = v[63] ? (~v + 64'd1) : v;
      r   = (mag + (64'd1 << (AXIS_FRAC - 1))) >> AXIS_FRAC;
      return v[63] ? -wide_type'(r) : wide_type'(r);
   endfunction

   function automatic word_type clamp_axis(input wide_type v);
      word_type r;
      if (v > (64'sd1 <<< AXIS_FRAC)) begin
         r = 32'sd1 <<< AXIS_FRAC;
      end else if (v < -(64'sd1 <<< AXIS_FRAC)) begin
         r = -(32'sd1 <<< AXIS_FRAC);
      end else begin
         r = word_type'(v);
      end
      return r;
   endfunction

   function automatic word_type sat_word(input wide_type v);
      word_type r;
      if (v > 64'sd2147483647) begin
         r = 32'sh7fffffff;
      end else if (v < -64'sd2147483648) begin
         r = 32'sh80000000;
      end else begin
         r = word_type'(v);
      end
      return r;
   endfunction

endpackage

// File: rtl/lav_norm.sv
// Pipelined three-component vector normalizer, result in Q2.30.
// Stages: magnitude, leading-one search, scaling, squares, sum, one square
// root bit per stage, division set-up, one quotient bit per stage, sign.
// Depends on lav_pkg.
module lav_norm (
   input  logic                clock,
   input  logic                en,
   input  logic [2:0][63:0]    vec_in,
   output logic [2:0][31:0]    vec_out
);

   // Stage 0: magnitudes and the largest of them.
   logic [2:0][63:0] mag_c;
   logic [63:0]      top_c;
   logic [2:0][63:0] s0_mag_ff;
   logic [2:0]       s0_neg_ff;
   logic [63:0]      s0_top_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag_c[i] = vec_in[i][63] ? (~vec_in[i] + 64'd1) : vec_in[i];
      end
      top_c = mag_c[0];
      if (mag_c[1] > top_c) begin
         top_c = mag_c[1];
      end
      if (mag_c[2] > top_c) begin
         top_c = mag_c[2];
      end
   end

   // Stage 1: position of the leading one of the largest magnitude.
   logic [5:0]       pos_c;
   logic [2:0][63:0] s1_mag_ff;
   logic [2:0]       s1_neg_ff;
   logic             s1_zero_ff;
   logic [5:0]       s1_pos_ff;

   always_comb begin
      pos_c = '0;
      for (int b = 0; b < 64; b++) begin
         if (s0_top_ff[b]) begin
            pos_c = 6'(b);
         end
      end
   end

   // Stage 2: scale so that the largest magnitude sits in [2^29, 2^30).
   lav_pkg::norm_side_type side2_c;
   lav_pkg::norm_side_type s2_side_ff;
   logic [63:0]            shifted_c;

   always_comb begin
      side2_c.neg  = s1_neg_ff;
      side2_c.zero = s1_zero_ff;
      for (int i = 0; i < 3; i++) begin
         if (s1_pos_ff > 6'd29) begin
            shifted_c = s1_mag_ff[i] >> (s1_pos_ff - 6'd29);
         end else begin
            shifted_c = s1_mag_ff[i] << (6'd29 - s1_pos_ff);
         end
         side2_c.mag[i] = shifted_c[lav_pkg::MAG_W-1:0];
      end
   end

   // Stages 3 and 4: squares, then their sum.
   logic [2:0][2*lav_pkg::MAG_W-1:0] s3_sq_ff;
   lav_pkg::norm_side_type           s3_side_ff;
   logic [2*lav_pkg::MAG_W+1:0]      s4_sum_ff;
   lav_pkg::norm_side_type           s4_side_ff;

   // Square root, one result bit per stage.
   logic [32:0]                 rt_rem_ff  [lav_pkg::ROOT_W];
   logic [lav_pkg::ROOT_W-1:0]  rt_root_ff [lav_pkg::ROOT_W];
   logic [2*lav_pkg::ROOT_W-1:0] rt_rad_ff [lav_pkg::ROOT_W];
   lav_pkg::norm_side_type      rt_side_ff [lav_pkg::ROOT_W];
   logic [32:0]                 rt_rem_in  [lav_pkg::ROOT_W];
   logic [lav_pkg::ROOT_W-1:0]  rt_root_in [lav_pkg::ROOT_W];

   always_comb begin
      logic [2*lav_pkg::ROOT_W-1:0] rad;
      logic [32:0]                  rem;
      logic [lav_pkg::ROOT_W-1:0]   root;
      logic [34:0]                  acc;
      logic [34:0]                  trial;
      for (int j = 0; j < lav_pkg::ROOT_W; j++) begin
         if (j == 0) begin
            rad  = s4_sum_ff;
            rem  = '0;
            root = '0;
         end else begin
            rad  = rt_rad_ff[j-1];
            rem  = rt_rem_ff[j-1];
            root = rt_root_ff[j-1];
         end
         acc   = {rem[32:0], rad[2*lav_pkg::ROOT_W-1-2*j -: 2]};
         trial = {2'b00, root, 2'b01};
         if (acc >= trial) begin
            rt_rem_in[j]  = 33'(acc - trial);
            rt_root_in[j] = {root[lav_pkg::ROOT_W-2:0], 1'b1};
         end else begin
            rt_rem_in[j]  = acc[32:0];
            rt_root_in[j] = {root[lav_pkg::ROOT_W-2:0], 1'b0};
         end
      end
   end

   // Division set-up: numerator is mag * 2^30 + len / 2.
   logic [lav_pkg::ROOT_W-1:0]           len_c;
   logic [2:0][60:0]                     num_c;
   logic [2:0][lav_pkg::QUO_W-1:0]       pv_rem_ff;
   logic [2:0][lav_pkg::QUO_W-1:0]       pv_low_ff;
   logic [lav_pkg::ROOT_W-1:0]           pv_len_ff;
   lav_pkg::norm_side_type               pv_side_ff;

   always_comb begin
      len_c = rt_root_ff[lav_pkg::ROOT_W-1];
      for (int i = 0; i < 3; i++) begin
         num_c[i] = {1'b0, rt_side_ff[lav_pkg::ROOT_W-1].mag[i], 30'b0}
                  + 61'(len_c >> 1);
      end
   end

   // Restoring division, one quotient bit per stage.
   logic [2:0][lav_pkg::QUO_W-1:0] dv_rem_ff  [lav_pkg::QUO_W];
   logic [2:0][lav_pkg::QUO_W-1:0] dv_q_ff    [lav_pkg::QUO_W];
   logic [2:0][lav_pkg::QUO_W-1:0] dv_low_ff  [lav_pkg::QUO_W];
   logic [lav_pkg::ROOT_W-1:0]     dv_len_ff  [lav_pkg::QUO_W];
   lav_pkg::norm_side_type         dv_side_ff [lav_pkg::QUO_W];
   logic [2:0][lav_pkg::QUO_W-1:0] dv_rem_in  [lav_pkg::QUO_W];
   logic [2:0][lav_pkg::QUO_W-1:0] dv_q_in    [lav_pkg::QUO_W];

   always_comb begin
      logic [2:0][lav_pkg::QUO_W-1:0] rem;
      logic [2:0][lav_pkg::QUO_W-1:0] quo;
      logic [2:0][lav_pkg::QUO_W-1:0] low;
      logic [lav_pkg::ROOT_W-1:0]     len;
      logic [lav_pkg::QUO_W:0]        part;
      for (int k = 0; k < lav_pkg::QUO_W; k++) begin
         if (k == 0) begin
            rem = pv_rem_ff;
            quo = '0;
            low = pv_low_ff;
            len = pv_len_ff;
         end else begin
            rem = dv_rem_ff[k-1];
            quo = dv_q_ff[k-1];
            low = dv_low_ff[k-1];
            len = dv_len_ff[k-1];
         end
         for (int i = 0; i < 3; i++) begin
            part = {rem[i], low[i][lav_pkg::QUO_W-1-k]};
            if (part >= {1'b0, len}) begin
               dv_rem_in[k][i] = lav_pkg::QUO_W'(part - {1'b0, len});
               dv_q_in[k][i]   = {quo[i][lav_pkg::QUO_W-2:0], 1'b1};
            end else begin
               dv_rem_in[k][i] = part[lav_pkg::QUO_W-1:0];
               dv_q_in[k][i]   = {quo[i][lav_pkg::QUO_W-2:0], 1'b0};
            end
         end
      end
   end

   // Final stage: sign back on, zero vector forced to zero.
   logic [2:0][31:0] out_ff;
   logic [2:0][31:0] out_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         if (dv_side_ff[lav_pkg::QUO_W-1].zero) begin
            out_in[i] = '0;
         end else if (dv_side_ff[lav_pkg::QUO_W-1].neg[i]) begin
            out_in[i] = -(32'(dv_q_ff[lav_pkg::QUO_W-1][i]));
         end else begin
            out_in[i] = 32'(dv_q_ff[lav_pkg::QUO_W-1][i]);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_mag_ff  <= mag_c;
         s0_top_ff  <= top_c;
         for (int i = 0; i < 3; i++) begin
            s0_neg_ff[i] <= vec_in[i][63];
         end
         s1_mag_ff  <= s0_mag_ff;
         s1_neg_ff  <= s0_neg_ff;
         s1_zero_ff <= (s0_top_ff == 64'd0);
         s1_pos_ff  <= pos_c;
         s2_side_ff <= side2_c;
         for (int i = 0; i < 3; i++) begin
            s3_sq_ff[i] <= (2*lav_pkg::MAG_W)'(s2_side_ff.mag[i])
                         * (2*lav_pkg::MAG_W)'(s2_side_ff.mag[i]);
         end
         s3_side_ff <= s2_side_ff;
         s4_sum_ff  <= (2*lav_pkg::MAG_W+2)'(s3_sq_ff[0])
                     + (2*lav_pkg::MAG_W+2)'(s3_sq_ff[1])
                     + (2*lav_pkg::MAG_W+2)'(s3_sq_ff[2]);
         s4_side_ff <= s3_side_ff;
         for (int j = 0; j < lav_pkg::ROOT_W; j++) begin
            rt_rem_ff[j]  <= rt_rem_in[j];
            rt_root_ff[j] <= rt_root_in[j];
            if (j == 0) begin
               rt_rad_ff[j]  <= s4_sum_ff;
               rt_side_ff[j] <= s4_side_ff;
            end else begin
               rt_rad_ff[j]  <= rt_rad_ff[j-1];
               rt_side_ff[j] <= rt_side_ff[j-1];
            end
         end
         for (int i = 0; i < 3; i++) begin
            pv_rem_ff[i] <= {1'b0, num_c[i][60:31]};
            pv_low_ff[i] <= num_c[i][30:0];
         end
         pv_len_ff  <= len_c;
         pv_side_ff <= rt_side_ff[lav_pkg::ROOT_W-1];
         for (int k = 0; k < lav_pkg::QUO_W; k++) begin
            dv_rem_ff[k] <= dv_rem_in[k];
            dv_q_ff[k]   <= dv_q_in[k];
            if (k == 0) begin
               dv_low_ff[k]  <= pv_low_ff;
               dv_len_ff[k]  <= pv_len_ff;
               dv_side_ff[k] <= pv_side_ff;
            end else begin
               dv_low_ff[k]  <= dv_low_ff[k-1];
               dv_len_ff[k]  <= dv_len_ff[k-1];
               dv_side_ff[k] <= dv_side_ff[k-1];
            end
         end
         out_ff <= out_in;
      end
   end

   assign vec_out = out_ff;

endmodule

// File: rtl/look_at_view_matrix.sv
// Top level of the right-handed look-at view matrix unit.
// Depends on lav_pkg and on lav_norm (two instances).
//
// Channel  Direction  Payload (lowest bits first)
// req      in         eye x,y,z; target x,y,z; up x,y,z (9 x 32, Q16.16)
// rsp      out        right, true up, back (Q2.30); shift right/up/back
//
// One item enters per cycle while no result is held. Each of the two
// normalizers has a 31-stage square root and a 31-stage divider. Reset
// clears only the valid bits. When a result is held by rsp_tready low, the
// whole pipeline holds and req_tready falls; nothing is dropped or repeated.
module look_at_view_matrix (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   // eye_x, eye_y, eye_z, target_x, target_y, target_z, up_x, up_y, up_z
   input  logic [287:0] req_tdata,
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // right_x, right_y, right_z, true_up_x, true_up_y, true_up_z,
   // back_x, back_y, back_z, shift_right, shift_up, shift_back
   output logic [383:0] rsp_tdata
);

   localparam int NL      = lav_pkg::NORM_LAT;
   localparam int UP_DLY  = NL + 1;
   localparam int BK_DLY  = NL + 2;
   localparam int EYE_DLY = 2 * NL + 3;

   logic                         en;
   logic [lav_pkg::PIPE_LAT-1:0] vld_ff;

   assign en         = !vld_ff[lav_pkg::PIPE_LAT-1] || rsp_tready;
   assign req_tready = en;
   assign rsp_tvalid = vld_ff[lav_pkg::PIPE_LAT-1];

   lav_pkg::word_type eye_c [3];
   lav_pkg::word_type tgt_c [3];
   lav_pkg::word_type up_c  [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         eye_c[i] = lav_pkg::word_type'(req_tdata[32*i +: 32]);
         tgt_c[i] = lav_pkg::word_type'(req_tdata[96 + 32*i +: 32]);
         up_c[i]  = lav_pkg::word_type'(req_tdata[192 + 32*i +: 32]);
      end
   end

   logic signed [32:0] d_ff [3];
   lav_pkg::word_type  up_dly_ff  [UP_DLY][3];
   lav_pkg::word_type  eye_dly_ff [EYE_DLY][3];
   lav_pkg::word_type  bk_dly_ff  [BK_DLY][3];

   logic [2:0][63:0] n1_in;
   logic [2:0][31:0] n1_out;
   logic [2:0][63:0] n2_in;
   logic [2:0][31:0] n2_out;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n1_in[i] = 64'(d_ff[i]);
      end
   end

   lav_norm u_norm_back (
      .clock   (clock),
      .en      (en),
      .vec_in  (n1_in),
      .vec_out (n1_out)
   );

   lav_pkg::word_type back_c [3];
   lav_pkg::word_type up_d   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         back_c[i] = lav_pkg::word_type'(n1_out[i]);
         up_d[i]   = up_dly_ff[UP_DLY-1][i];
      end
   end

   // Up cross back: products, then differences.
   lav_pkg::wide_type cx_p_ff [6];
   lav_pkg::wide_type cx_ff   [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         n2_in[i] = cx_ff[i];
      end
   end

   lav_norm u_norm_right (
      .clock   (clock),
      .en      (en),
      .vec_in  (n2_in),
      .vec_out (n2_out)
   );

   lav_pkg::word_type rt_c  [3];
   lav_pkg::word_type bk_d  [3];
   lav_pkg::word_type eye_d [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         rt_c[i]  = lav_pkg::word_type'(n2_out[i]);
         bk_d[i]  = bk_dly_ff[BK_DLY-1][i];
         eye_d[i] = eye_dly_ff[EYE_DLY-1][i];
      end
   end

   // Tail stages: back cross right and the dot products with the eye.
   lav_pkg::wide_type cp_ff [6];
   lav_pkg::wide_type dr_ff [3];
   lav_pkg::wide_type db_ff [3];
   lav_pkg::word_type p1_rt_ff [3];
   lav_pkg::word_type p1_bk_ff [3];
   lav_pkg::word_type p1_eye_ff [3];

   lav_pkg::wide_type tmp_ff [3];
   lav_pkg::wide_type sr_ff;
   lav_pkg::wide_type sb_ff;
   lav_pkg::word_type p2_rt_ff [3];
   lav_pkg::word_type p2_bk_ff [3];
   lav_pkg::word_type p2_eye_ff [3];

   lav_pkg::word_type tu_ff [3];
   lav_pkg::word_type shr_ff;
   lav_pkg::word_type shb_ff;
   lav_pkg::word_type p3_rt_ff [3];
   lav_pkg::word_type p3_bk_ff [3];
   lav_pkg::word_type p3_eye_ff [3];

   lav_pkg::wide_type dt_ff [3];
   lav_pkg::word_type p4_tu_ff [3];
   lav_pkg::word_type p4_rt_ff [3];
   lav_pkg::word_type p4_bk_ff [3];
   lav_pkg::word_type p4_shr_ff;
   lav_pkg::word_type p4_shb_ff;

   lav_pkg::wide_type st_ff;
   lav_pkg::word_type p5_tu_ff [3];
   lav_pkg::word_type p5_rt_ff [3];
   lav_pkg::word_type p5_bk_ff [3];
   lav_pkg::word_type p5_shr_ff;
   lav_pkg::word_type p5_shb_ff;

   lav_pkg::word_type sht_ff;
   lav_pkg::word_type p6_tu_ff [3];
   lav_pkg::word_type p6_rt_ff [3];
   lav_pkg::word_type p6_bk_ff [3];
   lav_pkg::word_type p6_shr_ff;
   lav_pkg::word_type p6_shb_ff;

   logic [383:0] rsp_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[lav_pkg::PIPE_LAT-2:0], req_tvalid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         for (int i = 0; i < 3; i++) begin
            d_ff[i] <= 33'(eye_c[i]) - 33'(tgt_c[i]);
            up_dly_ff[0][i]  <= up_c[i];
            eye_dly_ff[0][i] <= eye_c[i];
            bk_dly_ff[0][i]  <= back_c[i];
         end
         for (int j = 1; j < UP_DLY; j++) begin
            up_dly_ff[j] <= up_dly_ff[j-1];
         end
         for (int j = 1; j < EYE_DLY; j++) begin
            eye_dly_ff[j] <= eye_dly_ff[j-1];
         end
         for (int j = 1; j < BK_DLY; j++) begin
            bk_dly_ff[j] <= bk_dly_ff[j-1];
         end

         cx_p_ff[0] <= 64'(up_d[1]) * 64'(back_c[2]);
         cx_p_ff[1] <= 64'(up_d[2]) * 64'(back_c[1]);
         cx_p_ff[2] <= 64'(up_d[2]) * 64'(back_c[0]);
         cx_p_ff[3] <= 64'(up_d[0]) * 64'(back_c[2]);
         cx_p_ff[4] <= 64'(up_d[0]) * 64'(back_c[1]);
         cx_p_ff[5] <= 64'(up_d[1]) * 64'(back_c[0]);
         for (int i = 0; i < 3; i++) begin
            cx_ff[i] <= cx_p_ff[2*i] - cx_p_ff[2*i+1];
         end

         cp_ff[0] <= 64'(bk_d[1]) * 64'(rt_c[2]);
         cp_ff[1] <= 64'(bk_d[2]) * 64'(rt_c[1]);
         cp_ff[2] <= 64'(bk_d[2]) * 64'(rt_c[0]);
         cp_ff[3] <= 64'(bk_d[0]) * 64'(rt_c[2]);
         cp_ff[4] <= 64'(bk_d[0]) * 64'(rt_c[1]);
         cp_ff[5] <= 64'(bk_d[1]) * 64'(rt_c[0]);
         for (int i = 0; i < 3; i++) begin
            dr_ff[i]     <= 64'(rt_c[i]) * 64'(eye_d[i]);
            db_ff[i]     <= 64'(bk_d[i]) * 64'(eye_d[i]);
            p1_rt_ff[i]  <= rt_c[i];
            p1_bk_ff[i]  <= bk_d[i];
            p1_eye_ff[i] <= eye_d[i];
         end

         for (int i = 0; i < 3; i++) begin
            tmp_ff[i]    <= cp_ff[2*i] - cp_ff[2*i+1];
            p2_rt_ff[i]  <= p1_rt_ff[i];
            p2_bk_ff[i]  <= p1_bk_ff[i];
            p2_eye_ff[i] <= p1_eye_ff[i];
         end
         sr_ff <= dr_ff[0] + dr_ff[1] + dr_ff[2];
         sb_ff <= db_ff[0] + db_ff[1] + db_ff[2];

         for (int i = 0; i < 3; i++) begin
            tu_ff[i]     <= lav_pkg::clamp_axis(lav_pkg::round_axis(tmp_ff[i]));
            p3_rt_ff[i]  <= p2_rt_ff[i];
            p3_bk_ff[i]  <= p2_bk_ff[i];
            p3_eye_ff[i] <= p2_eye_ff[i];
         end
         shr_ff <= lav_pkg::sat_word(-lav_pkg::round_axis(sr_ff));
         shb_ff <= lav_pkg::sat_word(-lav_pkg::round_axis(sb_ff));

         for (int i = 0; i < 3; i++) begin
            dt_ff[i]    <= 64'(tu_ff[i]) * 64'(p3_eye_ff[i]);
            p4_tu_ff[i] <= tu_ff[i];
            p4_rt_ff[i] <= p3_rt_ff[i];
            p4_bk_ff[i] <= p3_bk_ff[i];
         end
         p4_shr_ff <= shr_ff;
         p4_shb_ff <= shb_ff;

         st_ff     <= dt_ff[0] + dt_ff[1] + dt_ff[2];
         p5_tu_ff  <= p4_tu_ff;
         p5_rt_ff  <= p4_rt_ff;
         p5_bk_ff  <= p4_bk_ff;
         p5_shr_ff <= p4_shr_ff;
         p5_shb_ff <= p4_shb_ff;

         sht_ff    <= lav_pkg::sat_word(-lav_pkg::round_axis(st_ff));
         p6_tu_ff  <= p5_tu_ff;
         p6_rt_ff  <= p5_rt_ff;
         p6_bk_ff  <= p5_bk_ff;
         p6_shr_ff <= p5_shr_ff;
         p6_shb_ff <= p5_shb_ff;

         rsp_data_ff <= {p6_shb_ff, sht_ff, p6_shr_ff,
                         p6_bk_ff[2], p6_bk_ff[1], p6_bk_ff[0],
                         p6_tu_ff[2], p6_tu_ff[1], p6_tu_ff[0],
                         p6_rt_ff[2], p6_rt_ff[1], p6_rt_ff[0]};
      end
   end

   // Field order: shift_back sits above shift_up, which sits above shift_right.
   assign rsp_tdata = rsp_data_ff;

endmodule

// File: rtl/lav_checker.sv
// Port-level checks for the look-at view matrix unit, bound to its top level.
// Depends only on the ports of look_at_view_matrix.
module lav_checker (
   input logic         clock,
   input logic         reset,
   input logic         req_tvalid,
   input logic         req_tready,
   input logic [287:0] req_tdata,
   input logic         rsp_tvalid,
   input logic         rsp_tready,
   input logic [383:0] rsp_tdata
);

   // No result may appear straight out of reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid after reset");

   // With no result waiting, the unit must take a new item.
   a_ready_free: assert property (@(posedge clock) disable iff (reset)
      !rsp_tvalid |-> req_tready)
      else $error("input stalled with empty output");

   // A held result keeps its payload.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("held result changed");

   // Axis entries right_x and back_z stay within plus and minus one in Q2.30.
   a_axis_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |->
         ($signed(rsp_tdata[31:0]) <= 32'sd1073741824) &&
         ($signed(rsp_tdata[31:0]) >= -32'sd1073741824) &&
         ($signed(rsp_tdata[287:256]) <= 32'sd1073741824) &&
         ($signed(rsp_tdata[287:256]) >= -32'sd1073741824))
      else $error("axis entry out of range");

endmodule

bind look_at_view_matrix lav_checker u_lav_checker (.*);
